### sv/rbt_pkg.sv
// Shared types and constants for the relay bank auto-off timer.
package rbt_pkg;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned SEL_W      = 8;
    localparam int unsigned RELAY_N    = 6;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 16;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam int unsigned FULL_TIME_UNITS = 720;
    localparam logic [TICKS_W-1:0] DEFAULT_RELOAD = TICKS_W'(FULL_TIME_UNITS / 4);

    localparam logic [SEL_W-1:0]   SEL_ALL        = 8'd0;
    localparam logic [SEL_W-1:0]   SEL_SUPPLY     = 8'd1;
    localparam logic [SEL_W-1:0]   SEL_LAST_RELAY = 8'd6;
    localparam logic [SEL_W-1:0]   SEL_MASK_QUERY = 8'd255;
    localparam logic [RELAY_N-1:0] CIRCUIT_BITS   = 6'b111110;

    localparam logic [0:0] REG_TIMEOUT_TICKS = 1'b0;

    typedef logic [RELAY_N-1:0] relay_vec_t;

    typedef enum logic [OP_W-1:0] {
        OP_SWITCH_OFF = 2'd0,
        OP_SWITCH_ON  = 2'd1,
        OP_QUERY      = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

endpackage

### sv/relay_bank_auto_off_timer.sv
// Top level of the relay bank auto-off timer: request decode, relay state and countdown.
//
//  channel  | ports             | payload (low bit up)
//  ---------+-------------------+------------------------------------------------
//  request  | s_tvalid/s_tready | s_tdata: operation[1:0], relay_select[9:2]
//  result   | m_tvalid/m_tready | m_tdata: state_value[5:0], relay_drive[11:6]
//  config   | APB psel/penable  | 0x0 timeout_ticks[15:0]
//
// One request per cycle: the relay and countdown update is a single pass from
// s_tdata into the result register, one result per request.
// s_tready drops only while a held result is not taken by m_tready.
// Synchronous active-low reset: relays off, countdown and timeout_ticks at 180.
module relay_bank_auto_off_timer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation[1:0], relay_select[9:2], zero fill
    input  logic [rbt_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // state_value[5:0], relay_drive[11:6], zero fill
    output logic [rbt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rbt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rbt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rbt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import rbt_pkg::*;

    logic [TICKS_W-1:0] timeout_reg;
    logic [TICKS_W-1:0] countdown_reg, countdown_next;
    relay_vec_t         relay_on_reg, relay_on_next;
    logic               m_valid_reg;
    relay_vec_t         state_value_reg, state_value_next;

    op_t                op;
    logic [SEL_W-1:0]   sel;
    logic               sel_valid;
    logic [2:0]         sel_idx;
    relay_vec_t         sel_bits;
    relay_vec_t         mask_next;
    logic               accept;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == REG_TIMEOUT_TICKS) ?
                       APB_DATA_W'(timeout_reg) : '0;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({relay_on_reg, state_value_reg});

    assign op        = op_t'(s_tdata[OP_W-1:0]);
    assign sel       = s_tdata[OP_W +: SEL_W];
    assign sel_idx   = 3'(sel[2:0] - 3'd1);
    assign sel_valid = (sel <= SEL_LAST_RELAY);

    always_comb begin
        if (sel == SEL_ALL) begin
            sel_bits = CIRCUIT_BITS;
        end else begin
            sel_bits = relay_vec_t'(6'd1 << sel_idx);
        end
    end

    always_comb begin
        relay_on_next  = relay_on_reg;
        countdown_next = countdown_reg;
        unique case (op)
            OP_SWITCH_OFF: begin
                if (sel_valid) begin
                    relay_on_next = relay_on_reg & ~sel_bits;
                end
            end
            OP_SWITCH_ON: begin
                if (sel_valid) begin
                    relay_on_next = relay_on_reg | sel_bits;
                    if (sel != SEL_SUPPLY) begin
                        countdown_next = timeout_reg;
                    end
                end
            end
            OP_QUERY: begin
            end
            OP_TICK: begin
                if (countdown_reg <= TICKS_W'(1)) begin
                    relay_on_next  = relay_on_reg & ~CIRCUIT_BITS;
                    countdown_next = timeout_reg;
                end else begin
                    countdown_next = countdown_reg - TICKS_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mask_next    = relay_on_next & CIRCUIT_BITS;
        mask_next[0] = |(relay_on_next & CIRCUIT_BITS);
        if (op == OP_QUERY) begin
            priority if (sel == SEL_ALL) begin
                state_value_next = relay_vec_t'(|(relay_on_reg & CIRCUIT_BITS));
            end else if (sel == SEL_MASK_QUERY) begin
                state_value_next = mask_next;
            end else if (sel_valid) begin
                state_value_next = relay_vec_t'((relay_on_reg >> sel_idx) & 6'd1);
            end else begin
                state_value_next = '0;
            end
        end else begin
            state_value_next = mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= DEFAULT_RELOAD;
            countdown_reg <= DEFAULT_RELOAD;
            relay_on_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_TIMEOUT_TICKS) begin
                timeout_reg <= pwdata[TICKS_W-1:0];
            end
            if (accept) begin
                relay_on_reg  <= relay_on_next;
                countdown_reg <= countdown_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            state_value_reg <= state_value_next;
        end
    end

    a_drive_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:6] == relay_on_reg)
        else $error("relay_drive differs from relay state");

    a_tick_expiry_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_TICK && countdown_reg <= TICKS_W'(1))
        |=> (relay_on_reg & CIRCUIT_BITS) == '0 && countdown_reg == $past(timeout_reg))
        else $error("expired countdown did not clear circuits");

    a_stall_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_valid_reg && !m_tready)
        else $error("request side stalled without a blocked result");

    a_query_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_QUERY)
        |=> $stable(relay_on_reg) && $stable(countdown_reg))
        else $error("query changed relay or countdown state");

endmodule

### tb/tb.sv
// Self-checking testbench for the relay bank auto-off timer: streamed requests, APB timeout writes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbt_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED  = 3'd4;
    localparam int unsigned ITEMS_PER_PHASE = 115;

    typedef enum logic [1:0] {
        JOB_REQUEST,
        JOB_CONFIG,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t               kind;
        op_t                     op;
        logic [SEL_W-1:0]        sel;
        logic [APB_ADDR_W-1:0]   addr;
        logic [APB_DATA_W-1:0]   wdata;
    } job_t;

    typedef struct packed {
        logic [5:0] state_value;
        relay_vec_t relay_drive;
    } bank_answer_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    relay_bank_auto_off_timer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    job_t               job_q[$];
    bank_answer_t       pending_answers[$];

    relay_vec_t         bank_relays    = '0;
    logic [TICKS_W-1:0] bank_countdown = DEFAULT_RELOAD;
    logic [TICKS_W-1:0] bank_reload    = DEFAULT_RELOAD;

    int unsigned mismatches    = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned timer_expiries = 0;
    int unsigned timeout_writes = 0;

    function automatic bank_answer_t bank_step(op_t op, logic [SEL_W-1:0] sel);
        relay_vec_t   hit;
        relay_vec_t   mask;
        bank_answer_t ans;
        logic         one_relay;
        one_relay = (sel >= SEL_SUPPLY) && (sel <= SEL_LAST_RELAY);
        if (sel == SEL_ALL) begin
            hit = CIRCUIT_BITS;
        end else if (one_relay) begin
            hit = relay_vec_t'(1) << (sel - SEL_SUPPLY);
        end else begin
            hit = '0;
        end
        case (op)
            OP_SWITCH_OFF: begin
                bank_relays &= ~hit;
            end
            OP_SWITCH_ON: begin
                bank_relays |= hit;
                if (hit != '0 && sel != SEL_SUPPLY) begin
                    bank_countdown = bank_reload;
                end
            end
            OP_TICK: begin
                if (bank_countdown <= 1) begin
                    bank_relays &= ~CIRCUIT_BITS;
                    bank_countdown = bank_reload;
                    timer_expiries++;
                end else begin
                    bank_countdown = bank_countdown - 1'b1;
                end
            end
            default: ;
        endcase
        mask = bank_relays & CIRCUIT_BITS;
        if (mask != '0) begin
            mask[0] = 1'b1;
        end
        ans.state_value = mask;
        if (op == OP_QUERY && sel != SEL_MASK_QUERY) begin
            if (sel == SEL_ALL) begin
                ans.state_value = {5'b0, |(bank_relays & CIRCUIT_BITS)};
            end else if (one_relay) begin
                ans.state_value = {5'b0, bank_relays[3'(sel - SEL_SUPPLY)]};
            end else begin
                ans.state_value = '0;
            end
        end
        ans.relay_drive = bank_relays;
        return ans;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    function automatic void queue_request(op_t op, logic [SEL_W-1:0] sel);
        job_t j;
        j.kind  = JOB_REQUEST;
        j.op    = op;
        j.sel   = sel;
        j.addr  = '0;
        j.wdata = '0;
        job_q.push_back(j);
    endfunction

    function automatic void queue_write(logic [APB_ADDR_W-1:0] addr, logic [TICKS_W-1:0] value);
        job_t j;
        j.kind  = JOB_CONFIG;
        j.op    = OP_QUERY;
        j.sel   = '0;
        j.addr  = addr;
        j.wdata = {16'($urandom), value};
        job_q.push_back(j);
    endfunction

    function automatic void queue_random_request();
        int unsigned r;
        int unsigned s;
        op_t         op;
        logic [SEL_W-1:0] sel;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            op = OP_TICK;
        end else if (r < 60) begin
            op = OP_SWITCH_ON;
        end else if (r < 75) begin
            op = OP_SWITCH_OFF;
        end else begin
            op = OP_QUERY;
        end
        s = $urandom_range(0, 19);
        if (s < 14) begin
            sel = SEL_W'($urandom_range(0, 6));
        end else if (s < 17) begin
            sel = SEL_MASK_QUERY;
        end else begin
            sel = SEL_W'($urandom_range(0, 255));
        end
        queue_request(op, sel);
    endfunction

    // driver
    job_t        cur_req;
    job_t        head_job;
    int unsigned send_gap = 0;
    int unsigned send_quiet = 0;
    int unsigned apb_step = 0;
    bit          fired;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            psel     <= 1'b0;
            penable  <= 1'b0;
            pwrite   <= 1'b0;
            apb_step = 0;
            send_gap = 0;
        end else if (apb_step == 1) begin
            penable <= 1'b1;
            apb_step = 2;
        end else if (apb_step == 2) begin
            if (pready) begin
                if (paddr == ADDR_TIMEOUT) begin
                    bank_reload = pwdata[TICKS_W-1:0];
                end
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
                apb_step = 0;
            end
        end else if (!(s_tvalid && !s_tready)) begin
            fired = s_tvalid;
            if (fired) begin
                pending_answers.push_back(bank_step(cur_req.op, cur_req.sel));
                requests_sent++;
                if (send_quiet != 0) begin
                    send_quiet--;
                    send_gap = 0;
                end else begin
                    if ($urandom_range(0, 39) == 0) begin
                        send_quiet = 30;
                    end
                    send_gap = $urandom_range(0, 3);
                end
            end
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (job_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (job_q[0].kind == JOB_REQUEST) begin
                cur_req = job_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, cur_req.sel, cur_req.op};
            end else begin
                s_tvalid <= 1'b0;
                if (!fired && pending_answers.size() == 0) begin
                    head_job = job_q.pop_front();
                    if (head_job.kind == JOB_CONFIG) begin
                        psel   <= 1'b1;
                        pwrite <= 1'b1;
                        paddr  <= head_job.addr;
                        pwdata <= head_job.wdata;
                        apb_step = 1;
                        timeout_writes++;
                    end
                end
            end
        end
    end

    // monitor
    bank_answer_t want;
    int unsigned  stall = 0;
    int unsigned  recv_quiet = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_answers.size() == 0) begin
                    report_mismatch("result with no request pending", 32'(m_tdata), 0);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata[5:0] !== want.state_value) begin
                        report_mismatch("state_value", 32'(m_tdata[5:0]),
                                        32'(want.state_value));
                    end
                    if (m_tdata[11:6] !== want.relay_drive) begin
                        report_mismatch("relay_drive", 32'(m_tdata[11:6]),
                                        32'(want.relay_drive));
                    end
                    if (m_tdata[M_TDATA_W-1:12] !== '0) begin
                        report_mismatch("tdata fill", 32'(m_tdata[M_TDATA_W-1:12]), 0);
                    end
                end
                if (recv_quiet != 0) begin
                    recv_quiet--;
                    stall = 0;
                end else begin
                    if ($urandom_range(0, 39) == 0) begin
                        recv_quiet = 30;
                    end
                    stall = $urandom_range(0, 3);
                end
            end
            if (stall != 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [TICKS_W-1:0] phase_timeout[8];
        job_t               drain_job;
        phase_timeout[0] = 16'd1;
        phase_timeout[1] = 16'd2;
        phase_timeout[2] = 16'd3;
        phase_timeout[3] = TICKS_W'($urandom_range(4, 12));
        phase_timeout[4] = 16'hFFFF;
        phase_timeout[5] = 16'd0;
        phase_timeout[6] = TICKS_W'($urandom_range(1, 65535));
        phase_timeout[7] = DEFAULT_RELOAD;

        queue_request(OP_QUERY, SEL_MASK_QUERY);
        queue_request(OP_QUERY, SEL_ALL);
        queue_request(OP_SWITCH_ON, SEL_SUPPLY);
        queue_request(OP_QUERY, SEL_SUPPLY);
        queue_request(OP_QUERY, SEL_MASK_QUERY);
        queue_request(OP_SWITCH_ON, 8'd3);
        queue_request(OP_QUERY, 8'd3);
        queue_request(OP_QUERY, SEL_MASK_QUERY);
        queue_request(OP_QUERY, SEL_ALL);
        queue_request(OP_QUERY, 8'd7);
        queue_request(OP_QUERY, 8'd254);
        queue_request(OP_SWITCH_ON, 8'd7);
        queue_request(OP_SWITCH_OFF, 8'd200);
        queue_request(OP_SWITCH_ON, SEL_ALL);
        queue_request(OP_QUERY, SEL_LAST_RELAY);
        queue_request(OP_SWITCH_OFF, 8'd2);
        queue_request(OP_SWITCH_OFF, SEL_SUPPLY);
        queue_request(OP_SWITCH_OFF, SEL_ALL);
        queue_request(OP_SWITCH_ON, SEL_LAST_RELAY);
        queue_request(OP_TICK, 8'd0);
        queue_request(OP_TICK, 8'd255);
        queue_request(OP_QUERY, SEL_MASK_QUERY);
        queue_write(ADDR_UNUSED, 16'd9);
        queue_write(ADDR_TIMEOUT, 16'd0);
        queue_request(OP_SWITCH_ON, 8'd4);
        queue_request(OP_TICK, 8'd4);
        queue_request(OP_QUERY, SEL_MASK_QUERY);
        queue_write(ADDR_TIMEOUT, 16'd1);
        queue_request(OP_SWITCH_ON, 8'd2);
        queue_request(OP_TICK, 8'd170);

        foreach (phase_timeout[p]) begin
            queue_write(ADDR_TIMEOUT, phase_timeout[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 2 && i == ITEMS_PER_PHASE / 2) begin
                    drain_job.kind = JOB_DRAIN;
                    job_q.push_back(drain_job);
                end
                queue_random_request();
            end
        end

        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (job_q.size() != 0 || s_tvalid || apb_step != 0 || pending_answers.size() != 0);
        repeat (8) @(posedge aclk);

        $display("Covered %0d requests and %0d results across %0d register writes.",
                 requests_sent, results_seen, timeout_writes);
        $display("The timer forced the circuits off %0d times; %0d mismatches.",
                 timer_expiries, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
